// ===== rtl/core/bbtrp_pkg.sv =====
// ----------------------------------------------------------------------------
// bbtrp_pkg: shared types and constants of the bus telegram receive parser
// Payload structs for both channels, event and command codes, register
// indexes, frame byte positions and the application code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bbtrp_pkg;

   // Frame position counter width and default frame length limit.
   localparam int POS_W               = 6;
   localparam int MAX_FRAME_BYTES_DEF = 39;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDRESS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd1;

   localparam logic [15:0] OWN_ADDRESS_RESET   = 16'h0000;
   localparam logic [7:0]  TIMEOUT_TICKS_RESET = 8'd5;

   // Input commands.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Result events.
   localparam logic [1:0] EV_NONE       = 2'd0;
   localparam logic [1:0] EV_ACK_REQ    = 2'd1;
   localparam logic [1:0] EV_PAYLOAD    = 2'd2;
   localparam logic [1:0] EV_FRAME_DONE = 2'd3;

   // Byte positions with a fixed role in the frame.
   localparam logic [POS_W-1:0] POS_CONTROL = 6'd0;
   localparam logic [POS_W-1:0] POS_SRC_HI  = 6'd1;
   localparam logic [POS_W-1:0] POS_SRC_LO  = 6'd2;
   localparam logic [POS_W-1:0] POS_DST_HI  = 6'd3;
   localparam logic [POS_W-1:0] POS_DST_LO  = 6'd4;
   localparam logic [POS_W-1:0] POS_LENGTH  = 6'd5;
   localparam logic [POS_W-1:0] POS_APCI_HI = 6'd6;
   localparam logic [POS_W-1:0] POS_APCI_LO = 6'd7;

   // The check byte sits this far past the length field value.
   localparam logic [POS_W-1:0] CHECK_OFFSET = 6'd7;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  data_byte;
      logic [3:0]  data_index;
      logic [7:0]  control_byte;
      logic [15:0] source_address;
      logic [15:0] target_address;
      logic        target_is_group;
      logic [2:0]  hop_count;
      logic [3:0]  payload_length;
      logic [9:0]  apci_code;
      logic [7:0]  checksum_xor;
      logic        addressed_to_me;
   } rsp_payload_type;

   // Short service codes keep only the high nibble; all others append the
   // low six bits below the nibble.
   function automatic logic [9:0] decode_apci(input logic [3:0] high,
                                              input logic [5:0] low);
      logic [9:0] code;
      case (high) inside
         4'h1, 4'h2, 4'h6, 4'h8, 4'h9, 4'hA, 4'hC, 4'hE: code = {6'd0, high};
         default:                                         code = {high, low};
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bbtrp_parser.sv =====
// ----------------------------------------------------------------------------
// bbtrp_parser: frame state and per-item result logic
// Holds the frame position, running XOR, idle counter and captured header
// fields, and forms the one result that each accepted item produces.
// ----------------------------------------------------------------------------
`default_nettype none

module bbtrp_parser
   import bbtrp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take,
   input  wire req_payload_type item,
   input  wire logic [15:0]     own_address,
   input  wire logic [7:0]      timeout_ticks,
   output      rsp_payload_type result
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       idle_ff, idle_in;
   logic [7:0]       control_ff, control_in;
   logic [15:0]      source_ff, source_in;
   logic [15:0]      target_ff, target_in;
   logic [7:0]       length_ff, length_in;
   logic [3:0]       apci_high_ff, apci_high_in;
   logic [5:0]       apci_low_ff, apci_low_in;
   logic [3:0]       pidx_ff, pidx_in;

   logic             timed_out;
   logic             overlong;
   logic [POS_W-1:0] pos_start;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] check_pos;
   logic [7:0]       xor_new;
   logic [7:0]       b;
   logic             in_payload;
   logic             done;
   logic             is_group;

   always_comb begin
      b         = item.rx_byte;
      timed_out = idle_ff > timeout_ticks;
      pos_start = timed_out ? '0 : pos_ff;
      overlong  = pos_start >= MAX_POS;
      pos       = overlong ? '0 : pos_start;
      xor_new   = ((timed_out || overlong) ? 8'd0 : xor_ff) ^ b;

      control_in   = control_ff;
      source_in    = source_ff;
      target_in    = target_ff;
      length_in    = length_ff;
      apci_high_in = apci_high_ff;
      apci_low_in  = apci_low_ff;
      pidx_in      = overlong ? 4'd0 : pidx_ff;
      idle_in      = idle_ff;
      pos_in       = pos_ff;
      xor_in       = xor_ff;
      result       = '0;

      case (pos)
         POS_CONTROL: control_in       = b;
         POS_SRC_HI:  source_in[15:8]  = b;
         POS_SRC_LO:  source_in[7:0]   = b;
         POS_DST_HI:  target_in[15:8]  = b;
         POS_DST_LO:  target_in[7:0]   = b;
         POS_LENGTH: begin
            length_in        = b;
            result.event_res = EV_ACK_REQ;
         end
         POS_APCI_HI: apci_high_in = {b[1:0], 2'b00};
         POS_APCI_LO: begin
            apci_high_in      = apci_high_ff + {2'b00, b[7:6]};
            apci_low_in       = b[5:0];
            pidx_in           = 4'd0;
            result.event_res  = EV_PAYLOAD;
            result.data_byte  = {2'b00, b[5:0]};
            result.data_index = 4'd0;
         end
         default: ;
      endcase

      check_pos  = {2'b00, length_in[3:0]} + CHECK_OFFSET;
      in_payload = (pos > POS_APCI_LO) && (pos < check_pos);
      done       = pos == check_pos;
      is_group   = length_in[7];

      if (in_payload) begin
         pidx_in           = pidx_in + 4'd1;
         result.event_res  = EV_PAYLOAD;
         result.data_byte  = b;
         result.data_index = pidx_in;
      end

      if (done) begin
         result.event_res       = EV_FRAME_DONE;
         result.data_byte       = 8'd0;
         result.data_index      = 4'd0;
         result.control_byte    = control_in;
         result.source_address  = source_in;
         result.target_address  = target_in;
         result.target_is_group = is_group;
         result.hop_count       = length_in[6:4];
         result.payload_length  = length_in[3:0];
         result.apci_code       = decode_apci(apci_high_in, apci_low_in);
         result.checksum_xor    = xor_new;
         result.addressed_to_me = is_group || (target_in == own_address);
      end

      pos_in  = done ? '0 : pos + 6'd1;
      xor_in  = done ? 8'd0 : xor_new;
      idle_in = 8'd0;

      // A tick only advances the idle counter and reports nothing.
      if (item.cmd == CMD_TICK) begin
         control_in   = control_ff;
         source_in    = source_ff;
         target_in    = target_ff;
         length_in    = length_ff;
         apci_high_in = apci_high_ff;
         apci_low_in  = apci_low_ff;
         pidx_in      = pidx_ff;
         pos_in       = pos_ff;
         xor_in       = xor_ff;
         idle_in      = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;
         result       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         xor_ff       <= '0;
         idle_ff      <= '0;
         control_ff   <= '0;
         source_ff    <= '0;
         target_ff    <= '0;
         length_ff    <= '0;
         apci_high_ff <= '0;
         apci_low_ff  <= '0;
         pidx_ff      <= '0;
      end else if (take) begin
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
         idle_ff      <= idle_in;
         control_ff   <= control_in;
         source_ff    <= source_in;
         target_ff    <= target_in;
         length_ff    <= length_in;
         apci_high_ff <= apci_high_in;
         apci_low_ff  <= apci_low_in;
         pidx_ff      <= pidx_in;
      end
   end

   // A tick never moves the frame position.
   a_tick_keeps_position: assert property (@(posedge clock) disable iff (reset)
      take && item.cmd == CMD_TICK |=> pos_ff == $past(pos_ff))
      else $error("frame position moved on an idle tick");

   // Any received byte clears the idle counter.
   a_byte_clears_idle: assert property (@(posedge clock) disable iff (reset)
      take && item.cmd == CMD_BYTE |=> idle_ff == 8'd0)
      else $error("idle counter not cleared by a received byte");

endmodule

`default_nettype wire

// ===== rtl/core/bbtrp_out_buf.sv =====
// ----------------------------------------------------------------------------
// bbtrp_out_buf: two-entry result queue
// Holds finished results so that the input side keeps moving while the
// result side is stalled; full throughput with one entry in use.
// ----------------------------------------------------------------------------
`default_nettype none

module bbtrp_out_buf
   import bbtrp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire rsp_payload_type push_data,
   output      logic            full,
   output      logic            out_valid,
   input  wire logic            out_stall,
   output      rsp_payload_type out_data
);

   rsp_payload_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            pop;

   always_comb begin
      full      = count_ff == 2'd2;
      out_valid = count_ff != 2'd0;
      out_data  = entry_ff[rd_ptr_ff];
      pop       = out_valid && !out_stall;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_never_overfilled: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3 && !(push && full))
      else $error("result queue overflow");

   // The pointers differ exactly when one entry is held.
   a_pointer_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff != rd_ptr_ff) == (count_ff == 2'd1))
      else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== rtl/core/building_bus_telegram_receive_parser_core.sv =====
// ----------------------------------------------------------------------------
// building_bus_telegram_receive_parser_core: bus telegram receive parser
// Parses received bus bytes and idle ticks into acknowledge requests,
// payload bytes and frame-complete reports with the decoded header.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Moves
//   --------+-----------+----------------------+------------------------------
//   req_    | in        | req_valid/req_stall  | one byte or tick per transfer
//   rsp_    | out       | rsp_valid/rsp_stall  | one result per input transfer
//   csr_    | in        | csr_valid/csr_ready  | register index and write data
//
// Every input transfer yields exactly one result transfer, in the cycle after
// it at the earliest. The parser updates its frame state in the cycle of the
// transfer, so an input can be taken on every clock; the limit is the
// two-entry result queue, which raises req_stall only while it is full.
// Reset is synchronous and active high; it clears the frame state, the
// queue and the registers (own_address 0, timeout_ticks 5). csr_ready is
// always high. Write registers while no work is pending; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module building_bus_telegram_receive_parser_core
   import bbtrp_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input channel.
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_payload_type       req_payload,
   // Result channel.
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_payload_type       rsp_payload,
   // Configuration write channel.
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [15:0]     own_address_ff, own_address_in;
   logic [7:0]      timeout_ticks_ff, timeout_ticks_in;
   logic            take;
   logic            full;
   rsp_payload_type result;

   // Register file: a write to an index beyond the list is dropped.
   always_comb begin
      csr_ready        = 1'b1;
      own_address_in   = own_address_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OWN_ADDRESS:   own_address_in   = csr_wdata;
            CSR_TIMEOUT_TICKS: timeout_ticks_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff   <= OWN_ADDRESS_RESET;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
      end else begin
         own_address_ff   <= own_address_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   // An input transfer happens whenever the queue has room.
   assign req_stall = full;
   assign take      = req_valid && !req_stall;

   bbtrp_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .item          (req_payload),
      .own_address   (own_address_ff),
      .timeout_ticks (timeout_ticks_ff),
      .result        (result)
   );

   bbtrp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

endmodule

`default_nettype wire
